// File: sv/rcpa_pkg.sv
// Shared constants, types and codes of the reference-counted page allocator.
package rcpa_pkg;

   // Sizing of the managed memory
   localparam int NUM_PAGES    = 32768;
   localparam int PAGE_SIZE    = 4096;
   localparam int COUNT_BITS   = 8;

   localparam int IDX_BITS     = $clog2(NUM_PAGES);
   localparam int DEPTH_BITS   = $clog2(NUM_PAGES + 1);
   localparam int PAGE_SHIFT   = $clog2(PAGE_SIZE);
   localparam int CSR_IDX_BITS = 2;

   typedef logic [IDX_BITS-1:0]     page_idx_type;
   typedef logic [COUNT_BITS-1:0]   count_type;
   typedef logic [DEPTH_BITS-1:0]   depth_type;
   typedef logic [1:0]              req_code_type;
   typedef logic [2:0]              status_type;
   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;

   // Request kinds
   localparam req_code_type REQ_ALLOC = 2'd0;
   localparam req_code_type REQ_FREE  = 2'd1;
   localparam req_code_type REQ_INCR  = 2'd2;
   localparam req_code_type REQ_GET   = 2'd3;

   // Response status codes
   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_NO_MEM   = 3'd1;
   localparam status_type ST_BAD_ADDR = 3'd2;
   localparam status_type ST_ZERO     = 3'd3;
   localparam status_type ST_OVERFLOW = 3'd4;

   // Register indexes
   localparam csr_idx_type CSR_MEM_BASE   = 2'd0;
   localparam csr_idx_type CSR_KERNEL_END = 2'd1;
   localparam csr_idx_type CSR_MEM_TOP    = 2'd2;

   // Register reset values
   localparam logic [31:0] MEM_BASE_RST   = 32'h8000_0000;
   localparam logic [31:0] KERNEL_END_RST = 32'h8000_0000;
   localparam logic [31:0] MEM_TOP_RST    = 32'h8800_0000;

endpackage

// File: sv/rcpa_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module rcpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, and register the read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: sv/refcounted_page_allocator_core.sv
// Top level of the reference-counted page allocator: control, checks and memories.
//
// Usage:
//   The req_ channel carries one request per transaction: the request kind in
//   req_tuser and the page address in req_tdata. The rsp_ channel returns exactly
//   one result per request, in order: the status in rsp_tuser and the result
//   address, reference count and freed flag in rsp_tdata. The csr_ channel writes
//   mem_base, kernel_end and mem_top by index; it is always ready, and the
//   registers should only be changed while no request is in flight.
//   An accepted request is registered into the execute state, and its result is
//   then registered into the output register that drives rsp_tvalid. No new
//   request is taken before the last one has executed, as the count memory is
//   read on acceptance and written back on the following cycle, with the stack
//   memory accessed alongside. Reset: the free stack is emptied at once, then a
//   clearing pass writes a count of 1 into every entry of the count memory, one
//   entry per cycle; req_tready stays low during that pass while csr writes are
//   still taken.
//   Back-pressure: the result waits in the output register while rsp_tready is
//   low, and no new request is taken until that register is free or being read.
module refcounted_page_allocator_core (
   input  logic                       clock,
   input  logic                       reset,
   // Request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [31:0]                req_tdata,   // [31:0] page_addr
   input  logic [1:0]                 req_tuser,   // [1:0] req_type
   // Response channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [47:0]                rsp_tdata,   // [31:0] result_addr, [39:32] ref_count,
                                                   // [40] page_freed, [47:41] zero
   output logic [2:0]                 rsp_tuser,   // [2:0] status
   // Configuration channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [rcpa_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [31:0]                csr_data
);

   import rcpa_pkg::*;

   // Sequencer codes
   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   localparam page_idx_type LAST_IDX = page_idx_type'(NUM_PAGES - 1);

   logic [1:0]    state_ff, state_in;
   page_idx_type  clr_ff, clr_in;
   depth_type     depth_ff, depth_in;
   logic [31:0]   mem_base_ff, kernel_end_ff, mem_top_ff;
   req_code_type  op_ff, op_in;
   logic [31:0]   addr_ff, addr_in;
   page_idx_type  idx_ff, idx_in;
   logic          bad_ff, bad_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic [31:0]   rsp_addr_ff, rsp_addr_in;
   logic [7:0]    rsp_count_ff, rsp_count_in;
   logic          rsp_freed_ff, rsp_freed_in;

   logic          req_accept;
   logic [31:0]   req_off;
   logic          req_in_range, req_aligned, req_bad;
   page_idx_type  req_idx;

   logic          ref_we;
   page_idx_type  ref_waddr;
   count_type     ref_wdata;
   count_type     ref_rdata;
   logic          stk_we;
   page_idx_type  stk_waddr;
   page_idx_type  stk_wdata;
   page_idx_type  stk_raddr;
   page_idx_type  stk_rdata;

   logic [63:0]   alloc_off;
   logic [31:0]   alloc_addr;
   count_type     cnt_sel;
   logic [31:0]   cnt_wide;
   count_type     cnt_dec, cnt_inc;

   // Handshakes
   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   // Check the request address against the managed range, and for a free also its alignment and the kernel end
   assign req_off      = (req_tdata - mem_base_ff) >> PAGE_SHIFT;
   assign req_in_range = (req_tdata >= mem_base_ff) && (req_tdata < mem_top_ff) &&
                         (req_off < 32'(NUM_PAGES));
   assign req_aligned  = (req_tdata[PAGE_SHIFT-1:0] == '0);
   assign req_idx      = req_off[IDX_BITS-1:0];
   assign req_bad      = (req_tuser == REQ_FREE) ?
                         (!req_aligned || (req_tdata < kernel_end_ff) || !req_in_range) :
                         !req_in_range;

   // Address of the popped page
   assign alloc_off  = 64'(stk_rdata) << PAGE_SHIFT;
   assign alloc_addr = mem_base_ff + alloc_off[31:0];

   assign cnt_dec  = ref_rdata - count_type'(1);
   assign cnt_inc  = ref_rdata + count_type'(1);
   assign cnt_wide = 32'(cnt_sel);

   // Sequence clearing, acceptance and the read-modify-write step
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      depth_in      = depth_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      bad_in        = bad_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_freed_in  = rsp_freed_ff;
      ref_we        = 1'b0;
      ref_waddr     = clr_ff;
      ref_wdata     = count_type'(1);
      stk_we        = 1'b0;
      stk_waddr     = depth_ff[IDX_BITS-1:0];
      stk_wdata     = idx_ff;
      cnt_sel       = '0;
      case (state_ff)
         S_CLEAR: begin
            ref_we = 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + page_idx_type'(1);
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               op_in    = req_tuser;
               addr_in  = req_tdata;
               idx_in   = req_idx;
               bad_in   = req_bad;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_addr_in   = addr_ff;
            rsp_freed_in  = 1'b0;
            case (op_ff)
               REQ_ALLOC: begin
                  if (depth_ff == '0) begin
                     rsp_status_in = ST_NO_MEM;
                     rsp_addr_in   = '0;
                  end else begin
                     depth_in    = depth_ff - depth_type'(1);
                     ref_we      = 1'b1;
                     ref_waddr   = stk_rdata;
                     ref_wdata   = count_type'(1);
                     cnt_sel     = count_type'(1);
                     rsp_addr_in = alloc_addr;
                  end
               end
               REQ_FREE: begin
                  if (bad_ff) begin
                     rsp_status_in = ST_BAD_ADDR;
                  end else if (ref_rdata == '0) begin
                     rsp_status_in = ST_ZERO;
                  end else begin
                     ref_we    = 1'b1;
                     ref_waddr = idx_ff;
                     ref_wdata = cnt_dec;
                     cnt_sel   = cnt_dec;
                     if ((cnt_dec == '0) && (depth_ff < depth_type'(NUM_PAGES))) begin
                        stk_we       = 1'b1;
                        depth_in     = depth_ff + depth_type'(1);
                        rsp_freed_in = 1'b1;
                     end
                  end
               end
               REQ_INCR: begin
                  if (bad_ff) begin
                     rsp_status_in = ST_BAD_ADDR;
                  end else if (ref_rdata == '1) begin
                     rsp_status_in = ST_OVERFLOW;
                     cnt_sel       = ref_rdata;
                  end else begin
                     ref_we    = 1'b1;
                     ref_waddr = idx_ff;
                     ref_wdata = cnt_inc;
                     cnt_sel   = cnt_inc;
                  end
               end
               default: begin
                  if (bad_ff) begin
                     rsp_status_in = ST_BAD_ADDR;
                  end else begin
                     cnt_sel = ref_rdata;
                  end
               end
            endcase
            rsp_count_in = cnt_wide[7:0];
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold request and response payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      bad_ff        <= bad_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_freed_ff  <= rsp_freed_in;
   end

   // Take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mem_base_ff   <= MEM_BASE_RST;
         kernel_end_ff <= KERNEL_END_RST;
         mem_top_ff    <= MEM_TOP_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MEM_BASE:   mem_base_ff   <= csr_data;
            CSR_KERNEL_END: kernel_end_ff <= csr_data;
            CSR_MEM_TOP:    mem_top_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Reference count memory
   rcpa_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_PAGES)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (ref_waddr),
      .wr_data (ref_wdata),
      .rd_en   (req_accept),
      .rd_addr (req_idx),
      .rd_data (ref_rdata)
   );

   // Free page stack memory, read at the top entry
   assign stk_raddr = page_idx_type'(depth_ff - depth_type'(1));

   rcpa_ram #(
      .WIDTH (IDX_BITS),
      .DEPTH (NUM_PAGES)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (req_accept),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   // Drive the response channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, rsp_freed_ff, rsp_count_ff, rsp_addr_ff};

   // Every accepted request is executed on the next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_EXEC))
      else $error("accepted request not executed");

   // Execution always leaves a result in the output register
   a_exec_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |=> rsp_valid_ff)
      else $error("execution produced no result");

   // No request is taken during the clearing pass
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready)
      else $error("request taken while clearing");

   // The stack never holds more than the managed pages
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= depth_type'(NUM_PAGES))
      else $error("stack depth beyond capacity");

   // A push raises the stack depth by one
   a_push_depth: assert property (@(posedge clock) disable iff (reset)
      stk_we |=> (depth_ff == $past(depth_ff) + depth_type'(1)))
      else $error("push without depth update");

endmodule
